// File: rtl/prg_pkg.sv
// ----------------------------------------------------------------------------
// prg_pkg
// Types and constants shared by the ranged PCG32 generator: controller
// states, datapath command and status records, generator constants.
// ----------------------------------------------------------------------------
package prg_pkg;

   localparam int VALUE_WIDTH    = 64;
   localparam int HALF_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int DIV_CNT_WIDTH  = 6;
   localparam int STEP_WIDTH     = 3;

   localparam logic [VALUE_WIDTH-1:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;
   localparam int XS_SHIFT = 18;
   localparam int XS_POS   = 27;
   localparam int ROT_POS  = 59;
   localparam int ROT_WIDTH = 5;

   // register index, taken from paddr[CSR_INDEX_LSB]
   localparam logic REG_SEED = 1'b0;

   // draw steps: two advances of three multiply steps each
   localparam logic [STEP_WIDTH-1:0] STEP_LAST = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_CLASS,
      ST_LIMIT_DIV,
      ST_DRAW,
      ST_CHECK,
      ST_RESULT_DIV,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_RANGE,
      MODE_RAW,
      MODE_SINGLE
   } mode_type;

   typedef enum logic [1:0] {
      LCG_NONE,
      LCG_MUL_LO,
      LCG_MUL_MID,
      LCG_MUL_HI
   } lcg_op_type;

   typedef enum logic {
      DIV_FULL,
      DIV_DRAW
   } div_src_type;

   typedef enum logic [1:0] {
      OUT_RAW,
      OUT_MIN,
      OUT_SUM
   } out_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        load_span;
      logic        div_start;
      div_src_type div_src;
      logic        load_limit;
      lcg_op_type  lcg_op;
      logic        load_out;
      out_sel_type out_sel;
   } prg_cmd_type;

   typedef struct packed {
      logic span_zero;
      logic span_one;
      logic reject;
      logic div_done;
   } prg_status_type;

endpackage

// File: rtl/prg_if.sv
// ----------------------------------------------------------------------------
// prg_req_if / prg_rsp_if
// Valid/ready channels for range requests and random results.
// ----------------------------------------------------------------------------
interface prg_req_if;
   import prg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] lower_bound;
   logic signed [VALUE_WIDTH-1:0] upper_bound;

   modport source (output valid, output lower_bound, output upper_bound, input ready);
   modport sink (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface prg_rsp_if;
   import prg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// File: rtl/prg_divider.sv
// ----------------------------------------------------------------------------
// prg_divider
// Restoring serial divider, one quotient bit per cycle; keeps the remainder.
// ----------------------------------------------------------------------------
module prg_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [prg_pkg::VALUE_WIDTH-1:0]  dividend,
   input  logic [prg_pkg::VALUE_WIDTH-1:0]  divisor,
   output logic [prg_pkg::VALUE_WIDTH-1:0]  remainder,
   output logic                             done
);
   import prg_pkg::*;

   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [VALUE_WIDTH:0]     partial;
   logic [VALUE_WIDTH:0]     diff;

   assign partial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = partial - {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         // subtract when the divisor fits, else keep the shifted partial
         if (!diff[VALUE_WIDTH]) begin
            rem_in = diff[VALUE_WIDTH-1:0];
         end else begin
            rem_in = partial[VALUE_WIDTH-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {DIV_CNT_WIDTH{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// File: rtl/prg_datapath.sv
// ----------------------------------------------------------------------------
// prg_datapath
// Generator state, LCG advance in three multiply steps on one 32x32 multiplier, XSH-RR
// output, range registers, rejection limit and result register.
// ----------------------------------------------------------------------------
module prg_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  prg_pkg::prg_cmd_type                   cmd,
   output prg_pkg::prg_status_type                status,
   input  logic signed [prg_pkg::VALUE_WIDTH-1:0] req_lower,
   input  logic signed [prg_pkg::VALUE_WIDTH-1:0] req_upper,
   input  logic                                   seed_we,
   input  logic [prg_pkg::VALUE_WIDTH-1:0]        seed_wdata,
   output logic [prg_pkg::VALUE_WIDTH-1:0]        seed_value,
   output logic signed [prg_pkg::VALUE_WIDTH-1:0] out_value
);
   import prg_pkg::*;

   logic [VALUE_WIDTH-1:0] seed_ff, seed_in;
   logic [VALUE_WIDTH-1:0] inc_ff, inc_in;
   logic [VALUE_WIDTH-1:0] state_ff, state_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] draw_ff, draw_in;
   logic [VALUE_WIDTH-1:0] min_ff, min_in;
   logic [VALUE_WIDTH-1:0] max_ff, max_in;
   logic [VALUE_WIDTH-1:0] span_ff, span_in;
   logic [VALUE_WIDTH-1:0] limit_ff, limit_in;
   logic [VALUE_WIDTH-1:0] out_value_ff, out_value_in;

   logic [HALF_WIDTH-1:0]  mul_a, mul_b;
   logic [VALUE_WIDTH-1:0] mul_p;
   logic [VALUE_WIDTH-1:0] mul_upper;
   logic [VALUE_WIDTH-1:0] xsh;
   logic [HALF_WIDTH-1:0]  xs;
   logic [ROT_WIDTH-1:0]   rot;
   logic [VALUE_WIDTH-1:0] rot_pair;
   logic [HALF_WIDTH-1:0]  out32;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_rem;
   logic                   div_done;

   // multiplier operands by phase
   always_comb begin
      case (cmd.lcg_op)
         LCG_MUL_LO: begin
            mul_a = state_ff[HALF_WIDTH-1:0];
            mul_b = PCG_MULT[HALF_WIDTH-1:0];
         end
         LCG_MUL_MID: begin
            mul_a = state_ff[VALUE_WIDTH-1:HALF_WIDTH];
            mul_b = PCG_MULT[HALF_WIDTH-1:0];
         end
         LCG_MUL_HI: begin
            mul_a = state_ff[HALF_WIDTH-1:0];
            mul_b = PCG_MULT[VALUE_WIDTH-1:HALF_WIDTH];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p     = {{HALF_WIDTH{1'b0}}, mul_a} * {{HALF_WIDTH{1'b0}}, mul_b};
   assign mul_upper = {mul_p[HALF_WIDTH-1:0], {HALF_WIDTH{1'b0}}};

   // XSH-RR output from the state before the advance
   assign xsh      = state_ff ^ (state_ff >> XS_SHIFT);
   assign xs       = xsh[XS_POS +: HALF_WIDTH];
   assign rot      = state_ff[ROT_POS +: ROT_WIDTH];
   assign rot_pair = {xs, xs} >> rot;
   assign out32    = rot_pair[HALF_WIDTH-1:0];

   always_comb begin
      seed_in  = seed_ff;
      inc_in   = inc_ff;
      state_in = state_ff;
      acc_in   = acc_ff;
      draw_in  = draw_ff;
      case (cmd.lcg_op)
         LCG_MUL_LO:  acc_in = mul_p + inc_ff;
         LCG_MUL_MID: acc_in = acc_ff + mul_upper;
         LCG_MUL_HI: begin
            state_in = acc_ff + mul_upper;
            draw_in  = {draw_ff[HALF_WIDTH-1:0], out32};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
      // a fresh stream starts with the state equal to its increment
      if (seed_we) begin
         seed_in  = seed_wdata;
         inc_in   = {seed_wdata[VALUE_WIDTH-2:0], 1'b1};
         state_in = {seed_wdata[VALUE_WIDTH-2:0], 1'b1};
      end
   end

   // order the bounds by signed compare
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.load_req) begin
         if (req_lower > req_upper) begin
            min_in = req_upper;
            max_in = req_lower;
         end else begin
            min_in = req_lower;
            max_in = req_upper;
         end
      end
   end

   assign span_in  = cmd.load_span ? (max_ff - min_ff + 64'd1) : span_ff;
   assign limit_in = cmd.load_limit ? ({VALUE_WIDTH{1'b1}} - div_rem) : limit_ff;

   always_comb begin
      out_value_in = out_value_ff;
      if (cmd.load_out) begin
         case (cmd.out_sel)
            OUT_RAW: out_value_in = draw_ff;
            OUT_MIN: out_value_in = min_ff;
            OUT_SUM: out_value_in = min_ff + div_rem;
            default: out_value_in = out_value_ff;
         endcase
      end
   end

   assign div_dividend = (cmd.div_src == DIV_FULL) ? {VALUE_WIDTH{1'b1}} : draw_ff;

   prg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (span_ff),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         inc_ff   <= 64'd1;
         state_ff <= 64'd1;
      end else begin
         seed_ff  <= seed_in;
         inc_ff   <= inc_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      draw_ff      <= draw_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      span_ff      <= span_in;
      limit_ff     <= limit_in;
      out_value_ff <= out_value_in;
   end

   assign status.span_zero = (span_ff == '0);
   assign status.span_one  = (span_ff == 64'd1);
   assign status.reject    = (draw_ff >= limit_ff);
   assign status.div_done  = div_done;

   assign seed_value = seed_ff;
   assign out_value  = out_value_ff;

endmodule

// File: rtl/prg_ctrl.sv
// ----------------------------------------------------------------------------
// prg_ctrl
// Sequencer for one request: span, rejection limit, draws, final modulo,
// and the valid flag of the result register.
// ----------------------------------------------------------------------------
module prg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  prg_pkg::prg_status_type  status,
   output prg_pkg::prg_cmd_type     cmd
);
   import prg_pkg::*;

   ctrl_state_type        state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: state_in = ST_CLASS;
         ST_CLASS: begin
            step_in = '0;
            if (status.span_zero) begin
               mode_in  = MODE_RAW;
               state_in = ST_DRAW;
            end else if (status.span_one) begin
               mode_in  = MODE_SINGLE;
               state_in = ST_EMIT;
            end else begin
               mode_in  = MODE_RANGE;
               state_in = ST_LIMIT_DIV;
            end
         end
         ST_LIMIT_DIV: begin
            step_in = '0;
            if (status.div_done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = (mode_ff == MODE_RAW) ? ST_EMIT : ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            // redraw until below the limit
            state_in = status.reject ? ST_DRAW : ST_RESULT_DIV;
         end
         ST_RESULT_DIV: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.lcg_op     = LCG_NONE;
      cmd.div_src    = DIV_FULL;
      cmd.out_sel    = OUT_SUM;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_SPAN: cmd.load_span = 1'b1;
         ST_CLASS: begin
            cmd.div_start = !status.span_zero && !status.span_one;
            cmd.div_src   = DIV_FULL;
         end
         ST_LIMIT_DIV: cmd.load_limit = status.div_done;
         ST_DRAW: begin
            case (step_ff)
               3'd0, 3'd3: cmd.lcg_op = LCG_MUL_LO;
               3'd1, 3'd4: cmd.lcg_op = LCG_MUL_MID;
               3'd2, 3'd5: cmd.lcg_op = LCG_MUL_HI;
               default:    cmd.lcg_op = LCG_NONE;
            endcase
         end
         ST_CHECK: begin
            cmd.div_start = !status.reject;
            cmd.div_src   = DIV_DRAW;
         end
         ST_RESULT_DIV: cmd.div_src = DIV_DRAW;
         ST_EMIT: begin
            cmd.load_out = out_free;
            case (mode_ff)
               MODE_RAW:    cmd.out_sel = OUT_RAW;
               MODE_SINGLE: cmd.out_sel = OUT_MIN;
               default:     cmd.out_sel = OUT_SUM;
            endcase
         end
         default: cmd.lcg_op = LCG_NONE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RANGE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// File: rtl/pcg32_ranged_random_generator.sv
// ----------------------------------------------------------------------------
// pcg32_ranged_random_generator
// PCG32 XSH-RR generator answering ranged 64-bit requests by rejection sampling.
// ----------------------------------------------------------------------------
// A bounded range takes two passes of the serial remainder unit and a draw
// (two LCG advances on one 32x32 multiplier); each rejected draw is redone.
// A full range needs only the draw, a single-value range neither. One
// request at a time; the next is taken in the cycle after the result is
// loaded. Synchronous reset: state and increment 1, seed 0, result
// register empty.
module pcg32_ranged_random_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   prg_req_if.sink                              req_ch,
   prg_rsp_if.source                            rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [prg_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [prg_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [prg_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import prg_pkg::*;

   prg_cmd_type            cmd;
   prg_status_type         status;
   logic                   seed_we;
   logic [VALUE_WIDTH-1:0] seed_value;

   assign csr_pready = 1'b1;
   assign seed_we    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_INDEX_LSB] == REG_SEED);
   assign csr_prdata = (csr_paddr[CSR_INDEX_LSB] == REG_SEED) ? seed_value : '0;

   prg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   prg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_lower  (req_ch.lower_bound),
      .req_upper  (req_ch.upper_bound),
      .seed_we    (seed_we),
      .seed_wdata (csr_pwdata),
      .seed_value (seed_value),
      .out_value  (rsp_ch.value)
   );

endmodule
